// ===== rtl/u8e_pkg.sv =====
// Shared types, constants and helpers for the UTF-8 character escaper.
package u8e_pkg;

  localparam int CODE_W     = 21;
  localparam int RAW_W      = 32;
  localparam int LEN_W      = 3;
  localparam int MAX_OUT    = 10;
  localparam int COUNT_W    = $clog2(MAX_OUT + 1);
  localparam int PTR_W      = $clog2(MAX_OUT);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_WHAT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_HOW      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSING_BRACKET = 2'd2;

  localparam logic [3:0]        ESCAPE_WHAT_RST     = 4'd5;
  localparam logic [3:0]        ESCAPE_HOW_RST      = 4'd0;
  localparam logic [CODE_W-1:0] CLOSING_BRACKET_RST = 21'd93;

  localparam logic [2:0] HOW_BSLASH = 3'd0;
  localparam logic [2:0] HOW_LETTER = 3'd1;
  localparam logic [2:0] HOW_BRACED = 3'd2;
  localparam logic [2:0] HOW_XHEX   = 3'd3;
  localparam logic [2:0] HOW_XHEX4  = 3'd4;
  localparam logic [2:0] HOW_SMART  = 3'd5;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_XU     = 8'h58;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [RAW_W-1:0]  raw;
    logic [LEN_W-1:0]  len;
    logic              flag;
    logic              bad;
  } chr_t;

  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [COUNT_W-1:0]      count;
    logic                    bad;
  } seq_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    hex_char = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
  endfunction

endpackage

// ===== rtl/u8e_decode.sv =====
// UTF-8 byte gatherer: builds code points and holds each finished character.
module u8e_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte,
  input  logic          check_bracket,
  output logic          chr_valid,
  output u8e_pkg::chr_t chr,
  input  logic          chr_take
);
  import u8e_pkg::*;

  logic [CODE_W-1:0] code_accum, code_next;
  logic [1:0]        bytes_left, left_next;
  logic [RAW_W-1:0]  raw_store, raw_next;
  logic [LEN_W-1:0]  char_len, len_next;
  logic              bracket_flag, flag_next;
  logic [LEN_W-1:0]  lead_len;
  logic [1:0]        pos;
  logic              done, bad, accept;

  assign in_stall = chr_valid && !chr_take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    code_next = code_accum;
    raw_next  = raw_store;
    len_next  = char_len;
    left_next = bytes_left;
    flag_next = bracket_flag;
    lead_len  = '0;
    pos       = char_len[1:0] - bytes_left;
    done      = 1'b0;
    bad       = 1'b0;
    if (bytes_left == 2'd0) begin
      if (in_byte < 8'h80) begin
        lead_len  = 3'd1;
        code_next = {13'd0, in_byte};
      end else if (in_byte < 8'hC0) begin
        bad = 1'b1;
      end else if (in_byte < 8'hE0) begin
        lead_len  = 3'd2;
        code_next = {16'd0, in_byte[4:0]};
      end else if (in_byte < 8'hF0) begin
        lead_len  = 3'd3;
        code_next = {17'd0, in_byte[3:0]};
      end else if (in_byte < 8'hF5) begin
        lead_len  = 3'd4;
        code_next = {18'd0, in_byte[2:0]};
      end else begin
        bad = 1'b1;
      end
      if (!bad) begin
        raw_next  = {24'd0, in_byte};
        len_next  = lead_len;
        left_next = lead_len[1:0] - 2'd1;
        flag_next = check_bracket;
        done      = (lead_len == 3'd1);
      end
    end else begin
      code_next = {code_accum[CODE_W-7:0], in_byte[5:0]};
      case (pos)
        2'd1:    raw_next[15:8]  = in_byte;
        2'd2:    raw_next[23:16] = in_byte;
        2'd3:    raw_next[31:24] = in_byte;
        default: raw_next[7:0]   = in_byte;
      endcase
      left_next = bytes_left - 2'd1;
      done      = (left_next == 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_accum   <= '0;
      bytes_left   <= '0;
      char_len     <= '0;
      bracket_flag <= 1'b0;
      chr_valid    <= 1'b0;
    end else begin
      if (chr_take) begin
        chr_valid <= 1'b0;
      end
      if (accept) begin
        code_accum   <= code_next;
        bytes_left   <= left_next;
        char_len     <= len_next;
        bracket_flag <= flag_next;
        if (done || bad) begin
          chr_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw_store <= raw_next;
      if (done || bad) begin
        chr.code <= code_next;
        chr.raw  <= raw_next;
        chr.len  <= len_next;
        chr.flag <= flag_next;
        chr.bad  <= bad;
      end
    end
  end

endmodule

// ===== rtl/u8e_format.sv =====
// Escape decision and output text builder for one finished character.
module u8e_format (
  input  u8e_pkg::chr_t               chr,
  input  logic [3:0]                  escape_what,
  input  logic [3:0]                  escape_how,
  input  logic [u8e_pkg::CODE_W-1:0]  closing_bracket,
  output u8e_pkg::seq_t               seq
);
  import u8e_pkg::*;

  logic [CODE_W-1:0] c;
  logic [23:0]       c_ext;
  logic              esc;
  logic [2:0]        how;
  logic [2:0]        stage;
  logic [2:0]        digits;
  logic [2:0]        nib_idx;
  logic              lower_bs;
  logic [7:0]        c_low;

  assign c     = chr.code;
  assign c_ext = {3'd0, c};
  assign c_low = c[7:0] | 8'h20;

  always_comb begin
    if (c == 21'h5C) begin
      esc = 1'b1;
    end else if (chr.flag && c == closing_bracket) begin
      esc = 1'b1;
    end else if (c > 21'hFFFF) begin
      esc = escape_what >= 4'd1;
    end else if (c >= 21'h4E00 && c <= 21'h9FFF) begin
      esc = escape_what >= 4'd4;
    end else if (c >= 21'hE000 && c <= 21'hF8FF) begin
      esc = escape_what >= 4'd2;
    end else if (c >= 21'h80) begin
      esc = escape_what >= 4'd3;
    end else if (c < 21'h20) begin
      esc = escape_what >= 4'd5;
    end else begin
      esc = escape_what >= 4'd7;
    end
  end

  always_comb begin
    how = (escape_how > 4'd5) ? HOW_BSLASH : escape_how[2:0];
    case (how)
      HOW_SMART, HOW_XHEX: stage = 3'd0;
      HOW_XHEX4:           stage = 3'd1;
      HOW_BRACED:          stage = 3'd2;
      HOW_LETTER:          stage = 3'd3;
      default:             stage = 3'd4;
    endcase
  end

  always_comb begin
    digits = 3'd1;
    for (int k = 1; k < 6; k++) begin
      if ((c_ext >> (4 * k)) != 24'd0) begin
        digits = 3'(k + 1);
      end
    end
  end

  // characters above 0xFF, or outside 'a'..'z' after case folding, get a backslash
  assign lower_bs = (c > 21'hFF) || (c_low < CH_A) || (c_low > 8'h7A);

  always_comb begin
    seq       = '0;
    nib_idx   = '0;
    if (chr.bad) begin
      seq.bad   = 1'b1;
      seq.count = 4'd1;
    end else if (!esc) begin
      for (int i = 0; i < 4; i++) begin
        seq.bytes[i] = chr.raw[8*i +: 8];
      end
      seq.count = {1'b0, chr.len};
    end else if (stage <= 3'd0 && (how == HOW_XHEX || c >= 21'h7F) && c <= 21'hFF) begin
      seq.bytes[0] = CH_BSLASH;
      seq.bytes[1] = CH_X;
      seq.bytes[2] = hex_char(c[7:4]);
      seq.bytes[3] = hex_char(c[3:0]);
      seq.count    = 4'd4;
    end else if (stage <= 3'd1 && (how == HOW_XHEX4 || c > 21'hFF) && c <= 21'hFFFF) begin
      seq.bytes[0] = CH_BSLASH;
      seq.bytes[1] = CH_XU;
      seq.bytes[2] = hex_char(c[15:12]);
      seq.bytes[3] = hex_char(c[11:8]);
      seq.bytes[4] = hex_char(c[7:4]);
      seq.bytes[5] = hex_char(c[3:0]);
      seq.count    = 4'd6;
    end else if (stage <= 3'd2 && (how == HOW_BRACED || c > 21'hFFFF)) begin
      seq.bytes[0] = CH_BSLASH;
      seq.bytes[1] = CH_X;
      seq.bytes[2] = CH_LBRACE;
      for (int i = 0; i < 6; i++) begin
        if (3'(i) < digits) begin
          nib_idx          = digits - 3'd1 - 3'(i);
          seq.bytes[3 + i] = hex_char(c_ext[4*nib_idx +: 4]);
        end
      end
      seq.bytes[3 + digits] = CH_RBRACE;
      seq.count             = 4'd4 + {1'b0, digits};
    end else if (stage <= 3'd3 && c >= 21'd1 && c <= 21'd27) begin
      seq.bytes[0] = CH_BSLASH;
      seq.count    = 4'd2;
      case (c[4:0])
        5'd7:    seq.bytes[1] = CH_A;
        5'd8:    seq.bytes[1] = CH_B;
        5'd27:   seq.bytes[1] = CH_E;
        5'd12:   seq.bytes[1] = CH_F;
        5'd9:    seq.bytes[1] = CH_T;
        5'd10:   seq.bytes[1] = CH_N;
        5'd13:   seq.bytes[1] = CH_R;
        default: begin
          seq.bytes[1] = CH_C;
          seq.bytes[2] = {3'b010, c[4:0]};
          seq.count    = 4'd3;
        end
      endcase
    end else if (how == HOW_SMART && (c <= 21'h1F || c == 21'h7F)) begin
      seq.bytes[0] = CH_BSLASH;
      seq.bytes[1] = CH_X;
      seq.bytes[2] = hex_char(c[7:4]);
      seq.bytes[3] = hex_char(c[3:0]);
      seq.count    = 4'd4;
    end else if (lower_bs) begin
      seq.bytes[0] = CH_BSLASH;
      for (int i = 0; i < 4; i++) begin
        seq.bytes[1 + i] = chr.raw[8*i +: 8];
      end
      seq.count = {1'b0, chr.len} + 4'd1;
    end else begin
      for (int i = 0; i < 4; i++) begin
        seq.bytes[i] = chr.raw[8*i +: 8];
      end
      seq.count = {1'b0, chr.len};
    end
  end

endmodule

// ===== rtl/u8e_emit.sv =====
// Output register: holds one character's text and sends it a byte per item.
module u8e_emit (
  input  logic          clk,
  input  logic          rst,
  input  logic          seq_valid_in,
  input  u8e_pkg::seq_t seq_in,
  output logic          seq_take,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          last_of_char,
  output logic          bad_lead
);
  import u8e_pkg::*;

  seq_t             seq;
  logic             seq_valid;
  logic [PTR_W-1:0] ptr;
  logic             at_end;

  assign at_end   = (COUNT_W'(ptr) == (seq.count - COUNT_W'(1)));
  assign seq_take = !seq_valid || (!out_stall && at_end);

  assign out_valid    = seq_valid;
  assign out_byte     = seq.bytes[ptr];
  assign last_of_char = at_end && !seq.bad;
  assign bad_lead     = seq.bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_valid <= 1'b0;
      ptr       <= '0;
    end else if (seq_take) begin
      seq_valid <= seq_valid_in;
      ptr       <= '0;
    end else if (!out_stall) begin
      ptr <= ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_take) begin
      seq <= seq_in;
    end
  end

endmodule

// ===== rtl/utf8_char_escaper_core.sv =====
// Top level of the UTF-8 character escaper.
//
// Input channel: one UTF-8 byte per item (in_byte) with check_bracket, taken
// with the lead byte, on in_valid / in_stall. Output channel: one text byte
// per item (out_byte, last_of_char, bad_lead) on out_valid / out_stall.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 escape_what, 1 escape_how, 2 closing_bracket); write only while idle.
// A character is held in the character register once its last input byte is
// accepted, then its text moves to the output register. A character makes 1
// to 10 output bytes, sent one per cycle from the output register while
// out_stall is low, so the output side sets the rate: one input byte per cycle
// while characters pass raw, and a character that expands holds the input
// while its text is sent. Continuation bytes are taken every cycle while the
// character register is free. A bad lead byte gives one item with bad_lead set, out_byte zero.
// Reset clears the decoder state and the pending output and loads register
// defaults 5, 0 and 93. While out_stall is high the current byte holds, and
// once the character and output registers are full in_stall rises.
module utf8_char_escaper_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_byte,
  input  logic                         check_bracket,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_byte,
  output logic                         last_of_char,
  output logic                         bad_lead,
  input  logic                         cfg_we,
  input  logic [u8e_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [u8e_pkg::CFG_DATA_W-1:0] cfg_data
);
  import u8e_pkg::*;

  logic [3:0]        escape_what;
  logic [3:0]        escape_how;
  logic [CODE_W-1:0] closing_bracket;
  logic              chr_valid, seq_take;
  chr_t              chr;
  seq_t              seq;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_what     <= ESCAPE_WHAT_RST;
      escape_how      <= ESCAPE_HOW_RST;
      closing_bracket <= CLOSING_BRACKET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ESCAPE_WHAT:     escape_what     <= cfg_data[3:0];
        REG_ESCAPE_HOW:      escape_how      <= cfg_data[3:0];
        REG_CLOSING_BRACKET: closing_bracket <= cfg_data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  u8e_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .check_bracket (check_bracket),
    .chr_valid     (chr_valid),
    .chr           (chr),
    .chr_take      (chr_valid && seq_take)
  );

  u8e_format u_format (
    .chr             (chr),
    .escape_what     (escape_what),
    .escape_how      (escape_how),
    .closing_bracket (closing_bracket),
    .seq             (seq)
  );

  u8e_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .seq_valid_in (chr_valid),
    .seq_in       (seq),
    .seq_take     (seq_take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last_of_char (last_of_char),
    .bad_lead     (bad_lead)
  );

endmodule

// ===== rtl/u8e_checker.sv =====
// Port-level assertions for the escaper top level, with its bind.
module u8e_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       last_of_char,
  input logic       bad_lead
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte)
      && $stable(last_of_char) && $stable(bad_lead))
    else $error("stalled output item changed");

  a_bad_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_lead |-> out_byte == 8'd0 && !last_of_char)
    else $error("bad lead item carries text");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no output pending");

endmodule

bind utf8_char_escaper_core u8e_checker u_checker (.*);

// ===== bench/u8e_escape_checker.sv =====
// Output checker for the UTF-8 character escaper: decodes the accepted input bytes itself and compares the text.
module u8e_escape_checker
  import u8e_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            in_byte,
  input  logic                  check_bracket,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [7:0]            out_byte,
  input  logic                  last_of_char,
  input  logic                  bad_lead,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output logic                  mid_char
);

  localparam logic [3:0] LVL_ASTRAL   = 4'd1;
  localparam logic [3:0] LVL_PRIV     = 4'd2;
  localparam logic [3:0] LVL_NONASCII = 4'd3;
  localparam logic [3:0] LVL_CJK      = 4'd4;
  localparam logic [3:0] LVL_CTRL     = 4'd5;
  localparam logic [3:0] LVL_OTHER    = 4'd7;

  localparam logic [7:0] ASC_ZERO    = 8'h30;
  localparam logic [7:0] ASC_UPPER_A = 8'h41;
  localparam logic [7:0] ASC_LOWER_Z = 8'h7A;
  localparam logic [7:0] CTRL_BIAS   = 8'h40;

  typedef struct packed {
    logic [7:0] text;
    logic       last;
    logic       bad;
  } text_item_t;

  text_item_t        expected_text[$];
  logic [7:0]        char_text[$];

  logic [3:0]        lvl_q;
  logic [3:0]        style_q;
  logic [CODE_W-1:0] brk_q;

  logic [CODE_W-1:0] cp_acc;
  logic [1:0]        left_n;
  logic [7:0]        raw_b [4];
  logic [LEN_W-1:0]  clen;
  logic              brk_chk;

  task automatic report_mismatch(string msg);
    $display("ERROR: %s", msg);
    fail_count++;
  endtask

  task automatic put_hex(logic [CODE_W-1:0] v, int digits);
    logic [3:0] nib;
    for (int i = digits - 1; i >= 0; i--) begin
      nib = 4'(v >> (4 * i));
      char_text.push_back((nib < 4'd10) ? ASC_ZERO + 8'(nib) : ASC_UPPER_A + 8'(nib) - 8'd10);
    end
  endtask

  task automatic put_raw();
    for (int i = 0; i < clen; i++) char_text.push_back(raw_b[i]);
  endtask

  // Escape decision and text for the character just completed.
  task automatic finish_char();
    logic [CODE_W-1:0] c;
    logic              esc;
    logic [2:0]        h;
    int                stage;
    int                d;
    int                n;
    c = cp_acc;
    char_text.delete();
    if (c == CH_BSLASH) esc = 1'b1;
    else if (brk_chk && c == brk_q) esc = 1'b1;
    else if (c > 21'hFFFF) esc = lvl_q >= LVL_ASTRAL;
    else if (c >= 21'h4E00 && c <= 21'h9FFF) esc = lvl_q >= LVL_CJK;
    else if (c >= 21'hE000 && c <= 21'hF8FF) esc = lvl_q >= LVL_PRIV;
    else if (c >= 21'h80) esc = lvl_q >= LVL_NONASCII;
    else if (c < 21'h20) esc = lvl_q >= LVL_CTRL;
    else esc = lvl_q >= LVL_OTHER;

    if (!esc) begin
      put_raw();
    end else begin
      h = (style_q > 4'd5) ? HOW_BSLASH : style_q[2:0];
      // styles enter a fall-through chain at different points
      if (h == HOW_SMART || h == HOW_XHEX) stage = 0;
      else if (h == HOW_XHEX4) stage = 1;
      else if (h == HOW_BRACED) stage = 2;
      else if (h == HOW_LETTER) stage = 3;
      else stage = 4;

      if (stage <= 0 && (h == HOW_XHEX || c >= 21'h7F) && c <= 21'hFF) begin
        char_text.push_back(CH_BSLASH);
        char_text.push_back(CH_X);
        put_hex(c, 2);
      end else if (stage <= 1 && (h == HOW_XHEX4 || c > 21'hFF) && c <= 21'hFFFF) begin
        char_text.push_back(CH_BSLASH);
        char_text.push_back(CH_XU);
        put_hex(c, 4);
      end else if (stage <= 2 && (h == HOW_BRACED || c > 21'hFFFF)) begin
        d = 1;
        while (d < 6 && (c >> (4 * d)) != 0) d++;
        char_text.push_back(CH_BSLASH);
        char_text.push_back(CH_X);
        char_text.push_back(CH_LBRACE);
        put_hex(c, d);
        char_text.push_back(CH_RBRACE);
      end else if (stage <= 3 && c >= 21'd1 && c <= 21'd27) begin
        char_text.push_back(CH_BSLASH);
        case (c)
          21'd7:  char_text.push_back(CH_A);
          21'd8:  char_text.push_back(CH_B);
          21'd27: char_text.push_back(CH_E);
          21'd12: char_text.push_back(CH_F);
          21'd9:  char_text.push_back(CH_T);
          21'd10: char_text.push_back(CH_N);
          21'd13: char_text.push_back(CH_R);
          default: begin
            char_text.push_back(CH_C);
            char_text.push_back(8'(c) + CTRL_BIAS);
          end
        endcase
      end else if (h == HOW_SMART && (c <= 21'h1F || c == 21'h7F)) begin
        char_text.push_back(CH_BSLASH);
        char_text.push_back(CH_X);
        put_hex(c, 2);
      end else begin
        if ((c | 21'h20) < CH_A || (c | 21'h20) > ASC_LOWER_Z) char_text.push_back(CH_BSLASH);
        put_raw();
      end
    end

    n = char_text.size();
    for (int i = 0; i < n; i++)
      expected_text.push_back('{text: char_text[i], last: (i == n - 1), bad: 1'b0});
  endtask

  always @(posedge clk) begin : observe
    text_item_t       want;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] pos;
    if (rst) begin
      lvl_q   = ESCAPE_WHAT_RST;
      style_q = ESCAPE_HOW_RST;
      brk_q   = CLOSING_BRACKET_RST;
      cp_acc  = '0;
      left_n  = '0;
      clen    = '0;
      brk_chk = 1'b0;
      for (int i = 0; i < 4; i++) raw_b[i] = '0;
      expected_text.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ESCAPE_WHAT:     lvl_q = cfg_data[3:0];
          REG_ESCAPE_HOW:      style_q = cfg_data[3:0];
          REG_CLOSING_BRACKET: brk_q = cfg_data[CODE_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (left_n == 2'd0) begin
          len = '0;
          if (in_byte < 8'h80) begin
            len = 3'd1;
            cp_acc = CODE_W'(in_byte);
          end else if (in_byte < 8'hC0) begin
            len = 3'd0;
          end else if (in_byte < 8'hE0) begin
            len = 3'd2;
            cp_acc = CODE_W'(in_byte[4:0]);
          end else if (in_byte < 8'hF0) begin
            len = 3'd3;
            cp_acc = CODE_W'(in_byte[3:0]);
          end else if (in_byte < 8'hF5) begin
            len = 3'd4;
            cp_acc = CODE_W'(in_byte[2:0]);
          end
          if (len == 3'd0) begin
            expected_text.push_back('{text: 8'h00, last: 1'b0, bad: 1'b1});
          end else begin
            raw_b[0] = in_byte;
            clen     = len;
            left_n   = 2'(len - 3'd1);
            brk_chk  = check_bracket;
            if (left_n == 2'd0) finish_char();
          end
        end else begin
          // any byte inside a character counts as a continuation
          pos = clen - 3'(left_n);
          cp_acc = {cp_acc[CODE_W-7:0], in_byte[5:0]};
          raw_b[pos[1:0]] = in_byte;
          left_n = left_n - 2'd1;
          if (left_n == 2'd0) finish_char();
        end
      end

      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected item: out_byte %h bad_lead %b",
                                    out_byte, bad_lead));
        end else begin
          want = expected_text.pop_front();
          if (out_byte !== want.text)
            report_mismatch($sformatf("out_byte expected %h got %h", want.text, out_byte));
          if (last_of_char !== want.last)
            report_mismatch($sformatf("last_of_char expected %b got %b",
                                      want.last, last_of_char));
          if (bad_lead !== want.bad)
            report_mismatch($sformatf("bad_lead expected %b got %b", want.bad, bad_lead));
        end
      end
    end
    pending  <= expected_text.size();
    mid_char <= (left_n != 2'd0);
  end

endmodule

// ===== bench/utf8_char_escaper_core_tb.sv =====
// Top of the UTF-8 character escaper testbench: clock, reset, register writes, byte stimulus and verdict.
module utf8_char_escaper_core_tb;
  import u8e_pkg::*;

  localparam int          HALF_PERIOD  = 6;
  localparam int          RESET_CYCLES = 6;
  localparam int          LIMIT_TIME   = 15_000_000;
  localparam int          NUM_PHASES   = 8;
  localparam int          PHASE_ITEMS  = 50;
  localparam int          IDLE_PAUSE   = 8;
  localparam int          END_PAUSE    = 20;
  localparam int          LONG_HOLD    = 400;
  localparam logic [20:0] CP_TOP       = 21'h13FFFF;
  localparam logic [7:0]  FILL_BYTE    = 8'h41;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic [7:0]            in_byte = '0;
  logic                  check_bracket = 1'b0;
  logic                  out_stall = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  wire                   in_stall;
  wire                   out_valid;
  wire  [7:0]            out_byte;
  wire                   last_of_char;
  wire                   bad_lead;

  int                    fail_count;
  int                    pending;
  logic                  mid_char;

  logic                  gaps_on = 1'b1;
  logic                  hold_req = 1'b0;
  logic                  hold_on = 1'b0;
  logic [20:0]           brk_now = CLOSING_BRACKET_RST;
  int                    phase_items;

  utf8_char_escaper_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .check_bracket(check_bracket),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .last_of_char(last_of_char), .bad_lead(bad_lead),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  u8e_escape_checker esc_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .check_bracket(check_bracket),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .last_of_char(last_of_char), .bad_lead(bad_lead),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .mid_char(mid_char)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int code_len(logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  task automatic send_item(logic [7:0] b, logic chk);
    int g;
    in_valid      <= 1'b1;
    in_byte       <= b;
    check_bracket <= chk;
    do @(posedge clk); while (in_stall);
    phase_items++;
    g = gaps_on ? pick_gap() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // len may exceed the natural length, which gives an overlong form
  task automatic send_code(logic [20:0] cp, int len, logic chk);
    logic [7:0] lead;
    case (len)
      1: lead = {1'b0, cp[6:0]};
      2: lead = {3'b110, cp[10:6]};
      3: lead = {4'b1110, cp[15:12]};
      default: lead = {5'b11110, cp[20:18]};
    endcase
    send_item(lead, chk);
    for (int k = len - 2; k >= 0; k--) send_item({2'b10, 6'(cp >> (6 * k))}, 1'($urandom));
  endtask

  task automatic send_random_char();
    int          r;
    logic [20:0] cp;
    logic        chk;
    r   = $urandom_range(0, 99);
    chk = ($urandom_range(0, 9) < 3);
    if (r < 8) begin
      send_item(8'($urandom), 1'($urandom));
    end else if (r < 14) begin
      // cut-short sequence: a long lead followed by a stray byte
      send_item(8'($urandom_range(8'hE0, 8'hF4)), chk);
      send_item(8'($urandom), 1'($urandom));
    end else if (r < 20) begin
      if (brk_now <= CP_TOP) send_code(brk_now, code_len(brk_now), 1'b1);
      else send_code(21'(CH_BSLASH), 1, chk);
    end else if (r < 25) begin
      send_code(21'(CH_BSLASH), 1, chk);
    end else if (r < 50) begin
      send_code(21'($urandom_range(0, 8'h7F)), 1, chk);
    end else if (r < 62) begin
      cp = ($urandom_range(0, 9) == 0) ? 21'($urandom_range(0, 21'h7F))
                                       : 21'($urandom_range(21'h80, 21'h7FF));
      send_code(cp, 2, chk);
    end else if (r < 80) begin
      case ($urandom_range(0, 3))
        0: cp = 21'($urandom_range(21'h4E00, 21'h9FFF));
        1: cp = 21'($urandom_range(21'hE000, 21'hF8FF));
        2: cp = 21'($urandom_range(21'h800, 21'hFFFF));
        default: cp = 21'($urandom_range(0, 21'hFFFF));
      endcase
      send_code(cp, 3, chk);
    end else begin
      cp = ($urandom_range(0, 7) == 0) ? 21'($urandom_range(0, CP_TOP))
                                       : 21'($urandom_range(21'h10000, CP_TOP));
      send_code(cp, 4, chk);
    end
  endtask

  task automatic write_regs(logic [3:0] what, logic [3:0] how, logic [20:0] brk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ESCAPE_WHAT;
    cfg_data  <= CFG_DATA_W'(what);
    @(posedge clk);
    cfg_index <= REG_ESCAPE_HOW;
    cfg_data  <= CFG_DATA_W'(how);
    @(posedge clk);
    cfg_index <= REG_CLOSING_BRACKET;
    cfg_data  <= brk;
    @(posedge clk);
    cfg_we  <= 1'b0;
    brk_now = brk;
  endtask

  // finish any partial character, then drain all text
  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mid_char) begin
      send_item(FILL_BYTE, 1'b0);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_code(21'h41, 1, 1'b0);
    send_code(21'h00, 1, 1'b0);
    send_code(21'h5C, 1, 1'b0);
    send_code(21'h5D, 1, 1'b1);
    send_code(21'hE9, 2, 1'b0);
    send_code(21'h4E00, 3, 1'b0);
    send_code(21'hE000, 3, 1'b0);
    send_code(21'h1F600, 4, 1'b0);
    send_code(21'h13FFFF, 4, 1'b0);
    send_item(8'h80, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'hF5, 1'b1);
    send_code(21'h00, 2, 1'b0);
    send_item(8'hE4, 1'b0);
    send_item(8'h41, 1'b0);
    send_item(8'h80, 1'b0);
    go_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: write_regs(4'd9, 4'(HOW_SMART), 21'd93);
        1: write_regs(4'd15, 4'(HOW_XHEX), 21'h10FFFF);
        2: write_regs(4'd0, 4'(HOW_BSLASH), 21'd0);
        3: write_regs(4'd7, 4'(HOW_LETTER), 21'h1FFFFF);
        4: write_regs(4'd4, 4'(HOW_BRACED), 21'($urandom_range(0, 8'h7F)));
        5: write_regs(4'd3, 4'(HOW_XHEX4), 21'($urandom_range(0, CP_TOP)));
        6: write_regs(4'd1, 4'd15, 21'($urandom));
        default: write_regs(4'($urandom), 4'($urandom), 21'($urandom_range(0, 16'hFFFF)));
      endcase
      gaps_on = (p != 3);
      if (p == 2) begin
        hold_req = 1'b1;
        wait (hold_on);
      end
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) send_random_char();
      go_idle();
    end

    repeat (END_PAUSE) @(posedge clk);
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int k;
    bit hold_done;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        // long hold-off so the block fills up and stalls its input
        out_stall <= 1'b1;
        hold_on = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end
      out_stall <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4))
        @(posedge clk);
      k = pick_gap();
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
    end
  end

  initial begin
    #(LIMIT_TIME);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
